### hdl/trbs_pkg.sv
// text row buffer package: sizes, op codes, register indexes, fsm states
// and the command group from controller to datapath; no dependencies
package trbs_pkg;

    localparam int MAX_COLUMNS  = 64;
    localparam int MAX_ROWS     = 32;
    localparam int CHAR_BITS    = 16;
    localparam int COL_BITS     = $clog2(MAX_COLUMNS);
    localparam int ROW_BITS     = $clog2(MAX_ROWS);
    localparam int LEN_BITS     = $clog2(MAX_COLUMNS + 1);
    localparam int CROW_BITS    = $clog2(MAX_ROWS + 1);
    localparam int CELL_DEPTH   = MAX_ROWS * MAX_COLUMNS;
    localparam int APB_ADDR_BITS = 3;
    localparam int IN_BITS      = 32;
    localparam int OUT_BITS     = 40;

    localparam logic [CHAR_BITS-1:0] NEWLINE_CODE = CHAR_BITS'(10);

    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_SCROLL = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } cmd_t;

endpackage

### hdl/text_row_buffer_scroll_core.sv
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata: op, char_code, read_row, read_column
// m_        out  m_tvalid/m_tready  m_tdata: cell_char, row_length, buffer_full,
//                                            cursor_row, cursor_column
// apb       in   psel/penable       reg 0 columns_in_use @0, reg 1 rows_in_use @4
//
// a request is handled in order: accept, execute (cell memory write or read),
// then load of the result register from the registered memory read
// a new request is taken while the previous result waits in the output register
// a stalled output holds the next result in the done step until m_tready
// reset is synchronous; row lengths clear at once, cell memory needs no clearing
// text row buffer top level; depends on trbs_pkg, trbs_ctrl, trbs_dp, trbs_ram
module text_row_buffer_scroll_core import trbs_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // [1:0] op, [17:2] char_code, [22:18] read_row, [28:23] read_column
    input  logic [IN_BITS-1:0]       s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [15:0] cell_char, [22:16] row_length, [23] buffer_full,
    // [29:24] cursor_row, [35:30] cursor_column
    output logic [OUT_BITS-1:0]      m_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    cmd_t cmd;

    assign pready = 1'b1;

    trbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    trbs_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata)
    );

endmodule

### hdl/trbs_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module trbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/trbs_ctrl.sv
// text row buffer controller: request sequencing and result handshake
// depends on trbs_pkg
module trbs_ctrl import trbs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_exec_then_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EXEC |=> state_reg == ST_DONE)
        else $error("execute step not followed by done");

    a_accept_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg == ST_EXEC)
        else $error("accepted request not executed");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_tvalid_reg && !m_tready) |=> state_reg == ST_DONE)
        else $error("result overwritten while output stalled");

endmodule

### hdl/trbs_dp.sv
// text row buffer datapath: config registers, ring pointers, row lengths,
// cell memory and result register; depends on trbs_pkg and trbs_ram
module trbs_dp import trbs_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cmd_t                     cmd,
    input  logic [IN_BITS-1:0]       s_tdata,
    output logic [OUT_BITS-1:0]      m_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata
);

    // latched request
    op_t                  op_reg;
    logic [CHAR_BITS-1:0] char_reg;
    logic [ROW_BITS-1:0]  rrow_reg;
    logic [COL_BITS-1:0]  rcol_reg;

    // buffer state
    logic [LEN_BITS-1:0]  cols_reg;
    logic [CROW_BITS-1:0] rows_reg;
    logic [ROW_BITS-1:0]  oldest_reg;
    logic [CROW_BITS-1:0] cur_row_reg;
    logic [COL_BITS-1:0]  cur_col_reg;
    logic [LEN_BITS-1:0]  len_reg [MAX_ROWS];

    // read lookup
    logic [LEN_BITS-1:0]  rd_len_reg;
    logic                 rd_hit_reg;

    // result
    logic [CHAR_BITS-1:0] out_cell_reg;
    logic [LEN_BITS-1:0]  out_len_reg;
    logic                 out_full_reg;
    logic [CROW_BITS-1:0] out_row_reg;
    logic [COL_BITS-1:0]  out_col_reg;

    logic                 cfg_wr;
    logic [LEN_BITS-1:0]  cfg_cols;
    logic [CROW_BITS-1:0] cfg_rows;
    logic                 full;
    logic [CROW_BITS:0]   cur_sum, cur_wrap, rd_sum, rd_wrap;
    logic [ROW_BITS-1:0]  cur_phys, rd_phys, oldest_inc;
    logic                 rd_in_range, rd_hit;
    logic [LEN_BITS-1:0]  rd_len, col_inc;
    logic                 push_char, push_nl;
    logic [CHAR_BITS-1:0] ram_rdata;

    assign cfg_wr = psel && penable && pwrite;
    assign cfg_cols = (pwdata[LEN_BITS-1:0] == '0) ? LEN_BITS'(1) :
                      (pwdata[LEN_BITS-1:0] > LEN_BITS'(MAX_COLUMNS)) ?
                      LEN_BITS'(MAX_COLUMNS) : pwdata[LEN_BITS-1:0];
    assign cfg_rows = (pwdata[CROW_BITS-1:0] > CROW_BITS'(MAX_ROWS)) ?
                      CROW_BITS'(MAX_ROWS) : pwdata[CROW_BITS-1:0];

    assign prdata = (paddr[2] == REG_ROWS) ? 32'(rows_reg) : 32'(cols_reg);

    assign full = cur_row_reg >= rows_reg;

    // logical to physical row, the cursor sum stays below twice the row count
    assign cur_sum  = (CROW_BITS+1)'(oldest_reg) + (CROW_BITS+1)'(cur_row_reg);
    assign cur_wrap = (cur_sum >= (CROW_BITS+1)'(rows_reg)) ?
                      cur_sum - (CROW_BITS+1)'(rows_reg) : cur_sum;
    assign cur_phys = cur_wrap[ROW_BITS-1:0];

    assign rd_sum   = (CROW_BITS+1)'(oldest_reg) + (CROW_BITS+1)'(rrow_reg);
    assign rd_wrap  = (rd_sum >= (CROW_BITS+1)'(rows_reg)) ?
                      rd_sum - (CROW_BITS+1)'(rows_reg) : rd_sum;
    assign rd_phys  = rd_wrap[ROW_BITS-1:0];

    assign rd_in_range = CROW_BITS'(rrow_reg) < rows_reg;
    assign rd_len      = rd_in_range ? len_reg[rd_phys] : '0;
    assign rd_hit      = rd_in_range && (LEN_BITS'(rcol_reg) < rd_len);

    assign oldest_inc = (CROW_BITS'(oldest_reg) + CROW_BITS'(1) == rows_reg) ?
                        '0 : oldest_reg + ROW_BITS'(1);

    assign col_inc   = LEN_BITS'(cur_col_reg) + LEN_BITS'(1);
    assign push_nl   = (op_reg == OP_PUSH) && !full && (char_reg == NEWLINE_CODE);
    assign push_char = (op_reg == OP_PUSH) && !full && (char_reg != NEWLINE_CODE)
                       && (char_reg != '0);

    trbs_ram #(
        .WIDTH (CHAR_BITS),
        .DEPTH (CELL_DEPTH)
    ) u_cells (
        .aclk  (aclk),
        .we    (cmd.exec && push_char),
        .waddr ({cur_phys, cur_col_reg}),
        .wdata (char_reg),
        .raddr ({rd_phys, rcol_reg}),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg   <= op_t'(s_tdata[1:0]);
            char_reg <= s_tdata[CHAR_BITS+1:2];
            rrow_reg <= s_tdata[CHAR_BITS+ROW_BITS+1:CHAR_BITS+2];
            rcol_reg <= s_tdata[CHAR_BITS+ROW_BITS+COL_BITS+1:CHAR_BITS+ROW_BITS+2];
        end
        if (cmd.exec) begin
            rd_len_reg <= rd_len;
            rd_hit_reg <= rd_hit;
        end
        if (cmd.load_out) begin
            out_cell_reg <= (op_reg == OP_READ && rd_hit_reg) ? ram_rdata : '0;
            out_len_reg  <= (op_reg == OP_READ) ? rd_len_reg : '0;
            out_full_reg <= full;
            out_row_reg  <= cur_row_reg;
            out_col_reg  <= cur_col_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg    <= LEN_BITS'(MAX_COLUMNS);
            rows_reg    <= CROW_BITS'(MAX_ROWS);
            oldest_reg  <= '0;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            for (int i = 0; i < MAX_ROWS; i++) begin
                len_reg[i] <= '0;
            end
        end else if (cfg_wr) begin
            if (paddr[2] == REG_COLUMNS) begin
                cols_reg    <= cfg_cols;
                oldest_reg  <= '0;
                cur_row_reg <= '0;
                cur_col_reg <= '0;
                for (int i = 0; i < MAX_ROWS; i++) begin
                    len_reg[i] <= '0;
                end
            end else if (pwdata[CROW_BITS-1:0] >= CROW_BITS'(2)) begin
                rows_reg    <= cfg_rows;
                oldest_reg  <= '0;
                cur_row_reg <= '0;
                cur_col_reg <= '0;
                for (int i = 0; i < MAX_ROWS; i++) begin
                    len_reg[i] <= '0;
                end
            end
        end else if (cmd.exec) begin
            case (op_reg)
                OP_PUSH: begin
                    if (push_nl) begin
                        cur_row_reg <= cur_row_reg + CROW_BITS'(1);
                        cur_col_reg <= '0;
                    end else if (push_char) begin
                        len_reg[cur_phys] <= col_inc;
                        if (col_inc >= cols_reg) begin
                            cur_row_reg <= cur_row_reg + CROW_BITS'(1);
                            cur_col_reg <= '0;
                        end else begin
                            cur_col_reg <= col_inc[COL_BITS-1:0];
                        end
                    end
                end
                OP_SCROLL: begin
                    len_reg[oldest_reg] <= '0;
                    oldest_reg  <= oldest_inc;
                    cur_row_reg <= rows_reg - CROW_BITS'(1);
                    cur_col_reg <= '0;
                end
                OP_CLEAR: begin
                    for (int i = 0; i < MAX_ROWS; i++) begin
                        len_reg[i] <= '0;
                    end
                    cur_row_reg <= '0;
                    cur_col_reg <= '0;
                end
                OP_READ: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tdata = {(OUT_BITS-CHAR_BITS-LEN_BITS-1-CROW_BITS-COL_BITS)'(0),
                      out_col_reg, out_row_reg, out_full_reg, out_len_reg, out_cell_reg};

    a_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        LEN_BITS'(cur_col_reg) < cols_reg)
        else $error("cursor column beyond row width");

    a_oldest_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        CROW_BITS'(oldest_reg) < rows_reg)
        else $error("oldest row outside ring");

    a_cursor_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_row_reg <= rows_reg)
        else $error("cursor row past full mark");

endmodule

### test/trbs_result_checker.sv
// result checker for the text row buffer: tracks the grid, ring order and cursor
// from the request, result and apb channels and compares every result field
// depends on trbs_pkg for sizes, op codes and register indexes
module trbs_result_checker import trbs_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [IN_BITS-1:0]       s_tdata,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [OUT_BITS-1:0]      m_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output int unsigned              results_outstanding,
    output int unsigned              mismatch_count
);

    typedef struct packed {
        logic [IN_BITS-2-CHAR_BITS-ROW_BITS-COL_BITS-1:0] pad;
        logic [COL_BITS-1:0]                              read_column;
        logic [ROW_BITS-1:0]                              read_row;
        logic [CHAR_BITS-1:0]                             char_code;
        op_t                                              op;
    } grid_request_t;

    typedef struct packed {
        logic [OUT_BITS-CHAR_BITS-LEN_BITS-1-CROW_BITS-COL_BITS-1:0] pad;
        logic [COL_BITS-1:0]                                       cursor_column;
        logic [CROW_BITS-1:0]                                      cursor_row;
        logic                                                      buffer_full;
        logic [LEN_BITS-1:0]                                       row_length;
        logic [CHAR_BITS-1:0]                                      cell_char;
    } grid_result_t;

    logic [CHAR_BITS-1:0] cell_mem [CELL_DEPTH];
    logic [LEN_BITS-1:0]  row_len [MAX_ROWS];
    int unsigned          head_row;
    int unsigned          cur_row;
    int unsigned          cur_col;
    int unsigned          col_limit;
    int unsigned          row_count;
    grid_result_t         expected_results [$];

    initial mismatch_count = 0;
    initial results_outstanding = 0;

    function automatic void empty_grid();
        foreach (row_len[i]) row_len[i] = '0;
        head_row = 0;
        cur_row  = 0;
        cur_col  = 0;
    endfunction

    function automatic void write_register(logic index, logic [31:0] value);
        int unsigned v;
        if (index == REG_COLUMNS) begin
            v = value[6:0];
            if (v < 1) v = 1;
            if (v > MAX_COLUMNS) v = MAX_COLUMNS;
            col_limit = v;
            empty_grid();
        end else begin
            v = value[5:0];
            // fewer than two rows is refused without touching the grid
            if (v >= 2) begin
                if (v > MAX_ROWS) v = MAX_ROWS;
                row_count = v;
                empty_grid();
            end
        end
    endfunction

    function automatic grid_result_t predict_grid_op(grid_request_t req);
        grid_result_t res;
        int unsigned  phys;
        res = '0;
        case (req.op)
            OP_PUSH: begin
                if (cur_row < row_count) begin
                    if (req.char_code == NEWLINE_CODE) begin
                        cur_row++;
                        cur_col = 0;
                    end else if (req.char_code != '0) begin
                        phys = (head_row + cur_row) % row_count;
                        cell_mem[phys * MAX_COLUMNS + cur_col] = req.char_code;
                        cur_col++;
                        row_len[phys] = LEN_BITS'(cur_col);
                        if (cur_col >= col_limit) begin
                            cur_row++;
                            cur_col = 0;
                        end
                    end
                end
            end
            OP_SCROLL: begin
                row_len[head_row] = '0;
                head_row = (head_row + 1) % row_count;
                cur_row  = row_count - 1;
                cur_col  = 0;
            end
            OP_CLEAR: begin
                foreach (row_len[i]) row_len[i] = '0;
                cur_row = 0;
                cur_col = 0;
            end
            default: begin
                if (req.read_row < row_count) begin
                    phys = (head_row + req.read_row) % row_count;
                    res.row_length = row_len[phys];
                    if (req.read_column < row_len[phys])
                        res.cell_char = cell_mem[phys * MAX_COLUMNS + req.read_column];
                end
            end
        endcase
        res.buffer_full   = (cur_row >= row_count);
        res.cursor_row    = CROW_BITS'(cur_row);
        res.cursor_column = COL_BITS'(cur_col);
        return res;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin : monitor
        grid_result_t got;
        grid_result_t want;
        if (!aresetn) begin
            col_limit = MAX_COLUMNS;
            row_count = MAX_ROWS;
            empty_grid();
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = grid_result_t'(m_tdata);
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: %h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("cell_char", want.cell_char, got.cell_char);
                    check_field("row_length", want.row_length, got.row_length);
                    check_field("buffer_full", want.buffer_full, got.buffer_full);
                    check_field("cursor_row", want.cursor_row, got.cursor_row);
                    check_field("cursor_column", want.cursor_column, got.cursor_column);
                end
            end
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
                write_register(paddr[2], pwdata);
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_grid_op(grid_request_t'(s_tdata)));
        end
        results_outstanding <= expected_results.size();
    end

endmodule

### test/tb_text_row_buffer_scroll_core.sv
// testbench top for text_row_buffer_scroll_core: directed and random requests
// under random idling and stalls; checking is done in trbs_result_checker
// depends on trbs_pkg, trbs_result_checker and the core
module tb_text_row_buffer_scroll_core;
    import trbs_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned PHASES         = 8;
    localparam int unsigned PHASE_REQUESTS = 200;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_BITS-1:0]       s_tdata;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_BITS-1:0]      m_tdata;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    int unsigned results_outstanding;
    int unsigned mismatch_count;
    int unsigned quiet_cycles = 0;
    int unsigned ready_run = 0;
    bit          no_gaps = 1'b0;
    bit          ready_always = 1'b0;
    int unsigned shape_cols = MAX_COLUMNS;
    int unsigned shape_rows = MAX_ROWS;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    text_row_buffer_scroll_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    trbs_result_checker grid_check (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .pready              (pready),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .results_outstanding (results_outstanding),
        .mismatch_count      (mismatch_count)
    );

    // mostly short pauses, a few long ones
    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    always @(posedge aclk) begin
        if (ready_always) begin
            m_tready  <= 1'b1;
            ready_run <= 0;
        end else if (ready_run != 0) begin
            ready_run <= ready_run - 1;
        end else if ($urandom_range(0, 99) < 50) begin
            m_tready  <= 1'b1;
            ready_run <= $urandom_range(0, 15);
        end else begin
            m_tready  <= 1'b0;
            ready_run <= pause_len() - 1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(op_t op, logic [CHAR_BITS-1:0] ch, logic [ROW_BITS-1:0] row,
                                logic [COL_BITS-1:0] col);
        int unsigned gap;
        gap = (no_gaps || $urandom_range(0, 99) < 55) ? 0 : pause_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_BITS'({col, row, ch, op});
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic random_request();
        int unsigned          pick;
        op_t                  op;
        logic [CHAR_BITS-1:0] ch;
        logic [ROW_BITS-1:0]  row;
        logic [COL_BITS-1:0]  col;
        pick = $urandom_range(0, 99);
        op   = (pick < 58) ? OP_PUSH : (pick < 66) ? OP_SCROLL : (pick < 68) ? OP_CLEAR : OP_READ;
        pick = $urandom_range(0, 99);
        ch   = (pick < 10) ? NEWLINE_CODE : (pick < 14) ? '0 : CHAR_BITS'($urandom);
        row  = ($urandom_range(0, 99) < 85) ? ROW_BITS'($urandom_range(0, shape_rows - 1))
                                            : ROW_BITS'($urandom);
        col  = ($urandom_range(0, 99) < 85) ? COL_BITS'($urandom_range(0, shape_cols - 1))
                                            : COL_BITS'($urandom);
        send_request(op, ch, row, col);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(logic index, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_BITS'({index, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // upper bits beyond each register are random and must be ignored
    task automatic configure(int unsigned cols, int unsigned rows);
        logic [31:0] cols_raw;
        logic [31:0] rows_raw;
        cols_raw = cols;
        rows_raw = rows;
        if (cols == 1 && $urandom_range(0, 1)) cols_raw = 0;
        if (cols == MAX_COLUMNS && $urandom_range(0, 1))
            cols_raw = $urandom_range(MAX_COLUMNS + 1, 127);
        if (rows == MAX_ROWS && $urandom_range(0, 1))
            rows_raw = $urandom_range(MAX_ROWS + 1, 63);
        apb_write(REG_COLUMNS, cols_raw | ($urandom & ~32'h7F));
        apb_write(REG_ROWS, rows_raw | ($urandom & ~32'h3F));
        shape_cols = cols;
        shape_rows = rows;
    endtask

    initial begin : stimulus
        int unsigned cols;
        int unsigned rows;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default size: wide characters, ignored zero, newline, reads, scroll, clear
        send_request(OP_PUSH, 16'hFFFF, '0, '0);
        send_request(OP_PUSH, 16'h0000, '0, '0);
        send_request(OP_PUSH, 16'hAAAA, '0, '0);
        send_request(OP_PUSH, 16'h5555, '0, '0);
        send_request(OP_PUSH, NEWLINE_CODE, '0, '0);
        send_request(OP_PUSH, 16'h0001, '0, '0);
        send_request(OP_READ, '0, 5'd0, 6'd0);
        send_request(OP_READ, '0, 5'd0, 6'd2);
        send_request(OP_READ, '0, 5'd0, 6'd3);
        send_request(OP_READ, '0, 5'd1, 6'd0);
        send_request(OP_READ, 16'hFFFF, 5'd31, 6'd63);
        send_request(OP_SCROLL, '0, '0, '0);
        send_request(OP_READ, '0, 5'd0, 6'd0);
        send_request(OP_CLEAR, '0, '0, '0);
        send_request(OP_READ, '0, 5'd0, 6'd0);
        wait_drained();

        // zero columns means one, a row count below two is refused
        apb_write(REG_COLUMNS, 32'd0);
        apb_write(REG_ROWS, 32'd2);
        apb_write(REG_ROWS, 32'd1);
        shape_cols = 1;
        shape_rows = 2;
        send_request(OP_PUSH, 16'h0041, '0, '0);
        send_request(OP_PUSH, 16'h0042, '0, '0);
        send_request(OP_PUSH, 16'h0043, '0, '0);
        send_request(OP_PUSH, NEWLINE_CODE, '0, '0);
        send_request(OP_READ, '0, 5'd2, 6'd0);
        send_request(OP_READ, '0, 5'd1, 6'd0);
        send_request(OP_SCROLL, '0, '0, '0);
        send_request(OP_READ, '0, 5'd0, 6'd0);
        send_request(OP_PUSH, 16'h0044, '0, '0);
        wait_drained();

        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            no_gaps      = (phase % 3 == 2);
            ready_always = (phase % 4 == 1);
            if (phase == 0) begin
                configure(1, 2);
            end else if (phase == 1) begin
                // oversized values saturate
                apb_write(REG_COLUMNS, 32'd100);
                apb_write(REG_ROWS, 32'd63);
                shape_cols = MAX_COLUMNS;
                shape_rows = MAX_ROWS;
            end else begin
                cols = $urandom_range(0, 1) ? $urandom_range(1, 8)
                                            : $urandom_range(1, MAX_COLUMNS);
                rows = $urandom_range(0, 1) ? $urandom_range(2, 6)
                                            : $urandom_range(2, MAX_ROWS);
                configure(cols, rows);
            end
            for (int unsigned n = 0; n < PHASE_REQUESTS; n++) begin
                if (n == PHASE_REQUESTS / 2) begin
                    wait_drained();
                    if (phase % 2 == 1)
                        apb_write(REG_ROWS, $urandom_range(0, 1) | ($urandom & ~32'h3F));
                end
                random_request();
            end
            wait_drained();
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_outstanding != 0);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### text_row_buffer_scroll_core.f
hdl/trbs_pkg.sv
hdl/trbs_ram.sv
hdl/trbs_ctrl.sv
hdl/trbs_dp.sv
hdl/text_row_buffer_scroll_core.sv
test/trbs_result_checker.sv
test/tb_text_row_buffer_scroll_core.sv
